>>> sv/rgbe_pkg.sv
// rgbe_pkg: transaction types and constants for the rgbe pixel encoder
// no dependencies; used by rgbe_fdiv and rgbe_pixel_encoder
`timescale 1ns / 1ps
`default_nettype none

package rgbe_pkg;

	typedef struct packed {
		logic [31:0] comp_a_bits;
		logic [31:0] comp_b_bits;
		logic [31:0] comp_c_bits;
		logic [31:0] weight_bits;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] mant_a;
		logic [7:0] mant_b;
		logic [7:0] mant_c;
		logic [7:0] shared_exp;
	} pix_out_t;

	// binary32 patterns
	localparam logic [31:0] ONE_BITS   = 32'h3F80_0000;
	localparam logic [31:0] INF_BITS   = 32'h7F80_0000;
	// nearest binary32 to 1e-32, below it a pixel is black
	localparam logic [31:0] BLACK_BITS = 32'h0A4F_B11F;

	// divider pipeline shape: quotient bits per stage and number of stages
	localparam int QBITS_PER_STAGE = 4;
	localparam int DIV_STAGES      = 7;
	localparam int QBITS           = QBITS_PER_STAGE * DIV_STAGES;

	// latency of one divider lane in cycles
	localparam int FDIV_LATENCY = DIV_STAGES + 3;

	// full encoder pipe: divider lanes, max/exponent stage, mantissa stage
	localparam int PIPE_STAGES = FDIV_LATENCY + 2;

	// biased exponent limits used by the shared exponent logic
	localparam logic [7:0] EBITS_CLAMP = 8'd253;
	localparam logic [7:0] EXP_SAT     = 8'd255;

endpackage

`default_nettype wire

>>> sv/rgbe_fdiv.sv
// rgbe_fdiv: pipelined binary32 divider lane, one quotient per cycle while en is high
// depends on rgbe_pkg; negative, nan and tiny quotients come out as +0
`timescale 1ns / 1ps
`default_nettype none

module rgbe_fdiv (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] num,
	input  wire logic [31:0] den,
	output logic      [31:0] quo
);

	typedef struct packed {
		logic kill;
		logic inf;
	} cls_t;

	function automatic logic [4:0] lzc23(input logic [22:0] f);
		logic [4:0] n;
		logic       found;
		n = 5'd0;
		found = 1'b0;
		for (int i = 22; i >= 0; i--) begin
			if (!found && f[i]) begin
				found = 1'b1;
				n = 5'(22 - i);
			end
		end
		return n;
	endfunction

	// normalized 24-bit mantissa and unbiased exponent of a finite value
	function automatic logic [34:0] unpack(input logic [31:0] b);
		logic [4:0]         lz;
		logic [23:0]        m;
		logic signed [10:0] e;
		lz = lzc23(b[22:0]);
		if (b[30:23] == 8'd0) begin
			m = {1'b0, b[22:0]} << (lz + 5'd1);
			e = -11'sd127 - $signed({6'd0, lz});
		end else begin
			m = {1'b1, b[22:0]};
			e = $signed({3'd0, b[30:23]}) - 11'sd127;
		end
		return {m, e};
	endfunction

	// four restoring steps: {remainder, quotient bits}
	function automatic logic [28:0] div4(input logic [24:0] r, input logic [23:0] d);
		logic [24:0] x;
		logic [25:0] t;
		logic [3:0]  q;
		x = r;
		for (int i = rgbe_pkg::QBITS_PER_STAGE - 1; i >= 0; i--) begin
			t = {1'b0, x} - {2'b0, d};
			q[i] = !t[25];
			if (!t[25]) begin
				x = t[24:0];
			end
			x = {x[23:0], 1'b0};
		end
		return {x, q};
	endfunction

	// stage 1: unpack and classify
	logic [23:0]        ma_s1, md_s1;
	logic signed [10:0] exp_s1;
	cls_t               cls_s1;

	logic [34:0] ua, ud;
	logic        a_nan, a_inf, a_zero, d_nan, d_inf;

	always_comb begin
		ua = unpack(num);
		ud = unpack(den);
		a_nan  = (num[30:23] == 8'hFF) && (num[22:0] != 23'd0);
		a_inf  = (num[30:23] == 8'hFF) && (num[22:0] == 23'd0);
		a_zero = (num[30:0] == 31'd0);
		d_nan  = (den[30:23] == 8'hFF) && (den[22:0] != 23'd0);
		d_inf  = (den[30:23] == 8'hFF) && (den[22:0] == 23'd0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= ua[34:11];
			md_s1  <= ud[34:11];
			exp_s1 <= $signed(ua[10:0]) - $signed(ud[10:0]);
			cls_s1.kill <= a_nan | d_nan | (a_inf & d_inf) | (num[31] ^ den[31]) | a_zero | d_inf;
			cls_s1.inf  <= a_inf & !(a_nan | d_nan | d_inf | (num[31] ^ den[31]));
		end
	end

	// stage 2 and divider stages share arrays; index 0 is stage 2
	logic [24:0]                 rem_s [rgbe_pkg::DIV_STAGES + 1];
	logic [rgbe_pkg::QBITS-1:0]  qb_s  [rgbe_pkg::DIV_STAGES + 1];
	logic [23:0]                 md_s  [rgbe_pkg::DIV_STAGES + 1];
	logic signed [10:0]          exp_s [rgbe_pkg::DIV_STAGES + 1];
	cls_t                        cls_s [rgbe_pkg::DIV_STAGES + 1];

	logic lt;
	assign lt = ma_s1 < md_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= lt ? {ma_s1, 1'b0} : {1'b0, ma_s1};
			qb_s[0]  <= '0;
			md_s[0]  <= md_s1;
			exp_s[0] <= exp_s1 - (lt ? 11'sd1 : 11'sd0);
			cls_s[0] <= cls_s1;
		end
	end

	for (genvar k = 1; k <= rgbe_pkg::DIV_STAGES; k++) begin : g_div
		logic [28:0] step;
		assign step = div4(rem_s[k-1], md_s[k-1]);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= step[28:4];
				qb_s[k]  <= {qb_s[k-1][rgbe_pkg::QBITS-rgbe_pkg::QBITS_PER_STAGE-1:0],
					step[3:0]};
				md_s[k]  <= md_s[k-1];
				exp_s[k] <= exp_s[k-1];
				cls_s[k] <= cls_s[k-1];
			end
		end
	end

	// last stage: round to nearest even and pack
	logic [rgbe_pkg::QBITS-1:0] qf;
	logic [24:0]                mr;
	logic                       inc, sticky;
	logic signed [10:0]         be;
	logic [31:0]                pat;

	always_comb begin
		qf = qb_s[rgbe_pkg::DIV_STAGES];
		sticky = (|qf[rgbe_pkg::QBITS-26:0]) | (rem_s[rgbe_pkg::DIV_STAGES] != 25'd0);
		inc = qf[rgbe_pkg::QBITS-25] & (sticky | qf[rgbe_pkg::QBITS-24]);
		mr = {1'b0, qf[rgbe_pkg::QBITS-1:rgbe_pkg::QBITS-24]} + {24'd0, inc};
		be = exp_s[rgbe_pkg::DIV_STAGES] + 11'sd127 + (mr[24] ? 11'sd1 : 11'sd0);
		if (cls_s[rgbe_pkg::DIV_STAGES].kill) begin
			pat = 32'd0;
		end else if (cls_s[rgbe_pkg::DIV_STAGES].inf || be >= 11'sd255) begin
			pat = rgbe_pkg::INF_BITS;
		end else if (be <= 11'sd0) begin
			// below the normal range: never above the black threshold
			pat = 32'd0;
		end else begin
			pat = {1'b0, be[7:0], mr[24] ? 23'd0 : mr[22:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= pat;
		end
	end

endmodule

`default_nettype wire

>>> sv/rgbe_pixel_encoder.sv
// rgbe_pixel_encoder: top level, weight division and shared exponent encoding
// depends on rgbe_pkg and rgbe_fdiv
`timescale 1ns / 1ps
`default_nettype none

// usage
//   pix channel (pix_valid / pix_ready / pix) takes one accumulated pixel per
//   transaction: three binary32 components and a binary32 weight
//   rgbe channel (rgbe_valid / rgbe_ready / rgbe) gives one rgbe pixel per
//   transaction: three mantissa bytes and a shared exponent biased by 128
//   a zero weight means the components are encoded as they are
// throughput: one transaction per cycle on each side while rgbe is taken
// pipe: from pix acceptance to rgbe_valid a pixel passes the
//   divider lanes (unpack, prenormalize, 7 stages of 4 restoring steps,
//   round) plus a max/exponent stage and a mantissa shift stage
// stall: the whole pipe holds when rgbe_valid is high and rgbe_ready low,
//   pix_ready drops in the same cycle; no transaction is lost or repeated
// reset: arst_n clears all valid bits, the pipe comes up empty and ready
module rgbe_pixel_encoder (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pix_valid,
	output logic                   pix_ready,
	input  wire rgbe_pkg::pix_in_t pix,
	output logic                   rgbe_valid,
	input  wire logic              rgbe_ready,
	output rgbe_pkg::pix_out_t     rgbe
);

	// global advance: the pipe moves whenever the output slot frees up
	logic en;
	assign en = !rgbe_valid || rgbe_ready;
	assign pix_ready = en;

	// valid bit for each pipeline stage
	logic [rgbe_pkg::PIPE_STAGES-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[rgbe_pkg::PIPE_STAGES-2:0], pix_valid};
		end
	end

	assign rgbe_valid = vld_q[rgbe_pkg::PIPE_STAGES-1];

	// zero weight (either sign) divides by one, which is exact
	logic [31:0] den;
	assign den = (pix.weight_bits[30:0] == 31'd0) ? rgbe_pkg::ONE_BITS : pix.weight_bits;

	logic [31:0] qa, qb, qc;

	rgbe_fdiv u_div_a (.clk, .en, .num(pix.comp_a_bits), .den, .quo(qa));
	rgbe_fdiv u_div_b (.clk, .en, .num(pix.comp_b_bits), .den, .quo(qb));
	rgbe_fdiv u_div_c (.clk, .en, .num(pix.comp_c_bits), .den, .quo(qc));

	// stage 11: largest component, black test, shared exponent
	// patterns are nonnegative, so integer compare orders them
	logic [31:0] mx;
	logic [7:0]  mx_e;

	always_comb begin
		mx = qa;
		if (qb > mx) begin
			mx = qb;
		end
		if (qc > mx) begin
			mx = qc;
		end
		mx_e = mx[30:23];
	end

	logic [31:0] pa_s11, pb_s11, pc_s11;
	logic [7:0]  eeff_s11, exp_s11;
	logic        black_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s11 <= qa;
			pb_s11 <= qb;
			pc_s11 <= qc;
			black_s11 <= mx < rgbe_pkg::BLACK_BITS;
			eeff_s11 <= (mx_e > rgbe_pkg::EBITS_CLAMP) ? rgbe_pkg::EBITS_CLAMP : mx_e;
			if (mx < rgbe_pkg::BLACK_BITS) begin
				exp_s11 <= 8'd0;
			end else if (mx_e > rgbe_pkg::EBITS_CLAMP) begin
				exp_s11 <= rgbe_pkg::EXP_SAT;
			end else begin
				exp_s11 <= mx_e + 8'd2;
			end
		end
	end

	// stage 12: floor(comp * 2^(8-e)) as a shift of the 24-bit mantissa;
	// shift amount is comp exponent - clamped max exponent + 7
	function automatic logic [7:0] mant_byte(input logic [31:0] p, input logic [7:0] ee);
		logic signed [9:0] sh;
		logic [23:0]       m;
		sh = $signed({2'd0, p[30:23]}) - $signed({2'd0, ee}) + 10'sd7;
		m = {1'b1, p[22:0]};
		if (sh < 10'sd0) begin
			return 8'd0;
		end else if (sh > 10'sd7) begin
			// scaled value at least 256, infinity included
			return 8'hFF;
		end else begin
			return 8'(m >> (5'd23 - {2'd0, sh[2:0]}));
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			rgbe.mant_a     <= black_s11 ? 8'd0 : mant_byte(pa_s11, eeff_s11);
			rgbe.mant_b     <= black_s11 ? 8'd0 : mant_byte(pb_s11, eeff_s11);
			rgbe.mant_c     <= black_s11 ? 8'd0 : mant_byte(pc_s11, eeff_s11);
			rgbe.shared_exp <= exp_s11;
		end
	end

	// black pixels carry zero mantissas
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		rgbe_valid && rgbe.shared_exp == 8'd0 |->
		rgbe.mant_a == 8'd0 && rgbe.mant_b == 8'd0 && rgbe.mant_c == 8'd0)
		else $error("black pixel with nonzero mantissa");

	// unsaturated exponent: the largest component fills the top mantissa bit
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		rgbe_valid && rgbe.shared_exp != 8'd0 && rgbe.shared_exp != rgbe_pkg::EXP_SAT |->
		rgbe.mant_a[7] || rgbe.mant_b[7] || rgbe.mant_c[7])
		else $error("shared exponent too large for largest component");

	// a stall freezes the valid pipe
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> vld_q == $past(vld_q))
		else $error("pipeline moved during stall");

endmodule

`default_nettype wire
